@@ src/mwo_pkg.sv @@
// shared types and constants for the mipmapped wavetable oscillator
package mwo_pkg;

   // fixed field widths
   localparam int SAMPLE_BITS     = 16;
   localparam int FRAC_BITS       = 16;
   localparam int MIX_BITS        = 16;
   localparam int STEP_BITS       = 27;
   localparam int SHIFT_BITS      = 11;
   localparam int LEVEL_BITS      = 4;
   localparam int ADDR_FIELD_BITS = 11;
   localparam int CSR_INDEX_BITS  = 2;

   // words per mipmap level, tied to the address field and the phase width
   localparam int WAVE_LEN        = 2048;

   // datapath arithmetic widths
   localparam int DIFF_W = SAMPLE_BITS + 1;               // neighbor word difference
   localparam int MOP_W  = DIFF_W + 1;                    // shared multiplier operand
   localparam int PROD_W = 2 * MOP_W;                     // shared multiplier product
   localparam int O_W    = SAMPLE_BITS + FRAC_BITS + 1;   // one level, interpolated
   localparam int D_W    = O_W + 1;                       // level difference
   localparam int DL_W   = MOP_W - 1;                     // low slice of level difference
   localparam int DH_W   = D_W - DL_W;                    // high slice of level difference
   localparam int ACC_W  = D_W + MIX_BITS + 2;            // crossfade accumulator
   localparam int OUT_LSB = FRAC_BITS + MIX_BITS;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PHASE_STEP   = 2'd0,
      CSR_OCTAVE_INDEX = 2'd1,
      CSR_OCTAVE_MIX   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_LO,   // lower level word difference times phase fraction
      MUL_HI,   // upper level word difference times phase fraction
      MUL_DL,   // low slice of level difference times mix
      MUL_DH    // high slice of level difference times mix
   } mul_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_MX1,
      ST_MX2,
      ST_MX3,
      ST_MX4,
      ST_MX5,
      ST_MX6,
      ST_MX7,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        tick_start;
      logic        word_write;
      logic        rd_hi;
      logic        rd_nxt;
      logic        ld_en;
      logic [1:0]  ld_idx;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        o1_en;
      logic        o2_en;
      logic        d_en;
      logic        acc_add_lo;
      logic        acc_add_hi;
      logic        out_en;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

endpackage

@@ src/mwo_ctrl.sv @@
// sequencer for table writes and tick reads, interpolation and crossfade steps
module mwo_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_operation,
   output logic                  req_ready,
   input  mwo_pkg::dp_status_type status,
   output mwo_pkg::ctl_cmd_type   cmd
);

   mwo_pkg::state_type state_ff;
   mwo_pkg::state_type state_in;
   logic               accept;

   assign accept = req_valid && req_ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mwo_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mwo_pkg::ST_IDLE: begin
            if (accept && (req_operation == mwo_pkg::OP_TICK)) begin
               state_in = mwo_pkg::ST_RD0;
            end
         end
         mwo_pkg::ST_RD0: state_in = mwo_pkg::ST_RD1;
         mwo_pkg::ST_RD1: state_in = mwo_pkg::ST_RD2;
         mwo_pkg::ST_RD2: state_in = mwo_pkg::ST_RD3;
         mwo_pkg::ST_RD3: state_in = mwo_pkg::ST_MX1;
         mwo_pkg::ST_MX1: state_in = mwo_pkg::ST_MX2;
         mwo_pkg::ST_MX2: state_in = mwo_pkg::ST_MX3;
         mwo_pkg::ST_MX3: state_in = mwo_pkg::ST_MX4;
         mwo_pkg::ST_MX4: state_in = mwo_pkg::ST_MX5;
         mwo_pkg::ST_MX5: state_in = mwo_pkg::ST_MX6;
         mwo_pkg::ST_MX6: state_in = mwo_pkg::ST_MX7;
         mwo_pkg::ST_MX7: state_in = mwo_pkg::ST_DONE;
         mwo_pkg::ST_DONE: begin
            if (!status.out_busy) begin
               state_in = mwo_pkg::ST_IDLE;
            end
         end
         default: state_in = mwo_pkg::ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      cmd.mul_sel = mwo_pkg::MUL_LO;
      unique case (state_ff)
         mwo_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.tick_start = req_valid && (req_operation == mwo_pkg::OP_TICK);
            cmd.word_write = req_valid && (req_operation == mwo_pkg::OP_WRITE);
         end
         mwo_pkg::ST_RD0: begin
            cmd.rd_hi  = 1'b0;
            cmd.rd_nxt = 1'b0;
         end
         mwo_pkg::ST_RD1: begin
            cmd.rd_nxt = 1'b1;
            cmd.ld_en  = 1'b1;
            cmd.ld_idx = 2'd0;
         end
         mwo_pkg::ST_RD2: begin
            cmd.rd_hi  = 1'b1;
            cmd.ld_en  = 1'b1;
            cmd.ld_idx = 2'd1;
         end
         mwo_pkg::ST_RD3: begin
            cmd.rd_hi   = 1'b1;
            cmd.rd_nxt  = 1'b1;
            cmd.ld_en   = 1'b1;
            cmd.ld_idx  = 2'd2;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = mwo_pkg::MUL_LO;
         end
         mwo_pkg::ST_MX1: begin
            cmd.ld_en  = 1'b1;
            cmd.ld_idx = 2'd3;
            cmd.o1_en  = 1'b1;
         end
         mwo_pkg::ST_MX2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = mwo_pkg::MUL_HI;
         end
         mwo_pkg::ST_MX3: cmd.o2_en = 1'b1;
         mwo_pkg::ST_MX4: cmd.d_en  = 1'b1;
         mwo_pkg::ST_MX5: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = mwo_pkg::MUL_DL;
         end
         mwo_pkg::ST_MX6: begin
            cmd.acc_add_lo = 1'b1;
            cmd.mul_en     = 1'b1;
            cmd.mul_sel    = mwo_pkg::MUL_DH;
         end
         mwo_pkg::ST_MX7: cmd.acc_add_hi = 1'b1;
         mwo_pkg::ST_DONE: cmd.out_en = !status.out_busy;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ src/mwo_datapath.sv @@
// table memory, phase and config registers, shared multiplier and output register
module mwo_datapath #(
   parameter int LEVELS = 11
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mwo_pkg::ctl_cmd_type                  cmd,
   input  logic [mwo_pkg::SHIFT_BITS-1:0]        req_shift,
   input  logic [mwo_pkg::LEVEL_BITS-1:0]        req_level,
   input  logic [mwo_pkg::ADDR_FIELD_BITS-1:0]   req_address,
   input  logic signed [mwo_pkg::SAMPLE_BITS-1:0] req_word,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [mwo_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [mwo_pkg::STEP_BITS-1:0]         csr_data,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic signed [mwo_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output mwo_pkg::dp_status_type                status
);

   // table size is a power of two, so position wrap is a plain truncation
   localparam int ADDR_BITS = $clog2(mwo_pkg::WAVE_LEN);
   localparam int LVL_W     = $clog2(LEVELS);
   localparam int PHASE_W   = ADDR_BITS + mwo_pkg::FRAC_BITS;
   localparam int MEM_DEPTH = LEVELS * mwo_pkg::WAVE_LEN;
   localparam int MEM_AW    = LVL_W + ADDR_BITS;
   localparam logic [31:0] NYQUIST_STEP = 32'(1) << (PHASE_W - 1);
   localparam logic [mwo_pkg::LEVEL_BITS:0] LAST_LEVEL = (mwo_pkg::LEVEL_BITS + 1)'(LEVELS - 1);

   // config and phase registers
   logic [PHASE_W-1:0]               step_ff;
   logic [mwo_pkg::LEVEL_BITS-1:0]   octave_ff;
   logic [mwo_pkg::MIX_BITS-1:0]     mix_ff;
   logic [PHASE_W-1:0]               phase_ff;
   logic [ADDR_BITS-1:0]             pos_ff;

   // table memory
   logic [mwo_pkg::SAMPLE_BITS-1:0]  mem_ram [MEM_DEPTH];
   logic [mwo_pkg::SAMPLE_BITS-1:0]  rdata_ff;
   logic [MEM_AW-1:0]                mem_addr;
   logic                             mem_we;

   // arithmetic registers
   logic signed [mwo_pkg::SAMPLE_BITS-1:0] w_ff [4];
   logic signed [mwo_pkg::PROD_W-1:0]      prod_ff;
   logic signed [mwo_pkg::O_W-1:0]         o1_ff;
   logic signed [mwo_pkg::O_W-1:0]         o2_ff;
   logic signed [mwo_pkg::D_W-1:0]         d_ff;
   logic signed [mwo_pkg::ACC_W-1:0]       acc_ff;
   logic                                   rsp_valid_ff;
   logic signed [mwo_pkg::SAMPLE_BITS-1:0] rsp_sample_ff;

   logic [mwo_pkg::LEVEL_BITS:0]      lo_full;
   logic [mwo_pkg::LEVEL_BITS:0]      hi_full;
   logic [LVL_W-1:0]                  rd_lvl;
   logic [ADDR_BITS-1:0]              rd_pos;
   logic [mwo_pkg::FRAC_BITS-1:0]     frac;
   logic signed [mwo_pkg::DIFF_W-1:0] diff_lo;
   logic signed [mwo_pkg::DIFF_W-1:0] diff_hi;
   logic signed [mwo_pkg::MOP_W-1:0]  mul_x;
   logic signed [mwo_pkg::MOP_W-1:0]  mul_y;
   logic signed [mwo_pkg::PROD_W-1:0] prod_in;
   logic signed [mwo_pkg::O_W-1:0]    o_sum;
   logic                              csr_write;
   logic                              wr_in_range;

   assign frac      = phase_ff[mwo_pkg::FRAC_BITS-1:0];
   assign csr_write = csr_valid && csr_ready;

   // config writes, step saturated at half the table
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= '0;
         octave_ff <= '0;
         mix_ff    <= '0;
      end else if (csr_write) begin
         case (mwo_pkg::csr_index_type'(csr_index))
            mwo_pkg::CSR_PHASE_STEP: begin
               if (32'(csr_data) > NYQUIST_STEP) begin
                  step_ff <= PHASE_W'(NYQUIST_STEP);
               end else begin
                  step_ff <= PHASE_W'(csr_data);
               end
            end
            mwo_pkg::CSR_OCTAVE_INDEX: octave_ff <= csr_data[mwo_pkg::LEVEL_BITS-1:0];
            mwo_pkg::CSR_OCTAVE_MIX:   mix_ff    <= csr_data[mwo_pkg::MIX_BITS-1:0];
            default: ;
         endcase
      end
   end

   // phase advances once the sample is handed to the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (cmd.out_en) begin
         phase_ff <= phase_ff + step_ff;
      end
   end

   // read position latched at tick start
   always_ff @(posedge clock) begin
      if (cmd.tick_start) begin
         pos_ff <= phase_ff[PHASE_W-1 -: ADDR_BITS] + ADDR_BITS'(req_shift);
      end
   end

   // level pair, lower clamped to last level, upper clamped too
   always_comb begin
      lo_full = {1'b0, octave_ff};
      if (lo_full > LAST_LEVEL) begin
         lo_full = LAST_LEVEL;
      end
      hi_full = lo_full + 1'b1;
      if (hi_full > LAST_LEVEL) begin
         hi_full = LAST_LEVEL;
      end
   end

   // single-port memory address
   assign wr_in_range = (32'(req_level) < 32'(LEVELS))
                     && (32'(req_address) < 32'(mwo_pkg::WAVE_LEN));
   assign mem_we      = cmd.word_write && wr_in_range;
   assign rd_lvl      = cmd.rd_hi ? hi_full[LVL_W-1:0] : lo_full[LVL_W-1:0];
   assign rd_pos      = cmd.rd_nxt ? (pos_ff + 1'b1) : pos_ff;
   assign mem_addr    = cmd.word_write ? {req_level[LVL_W-1:0], ADDR_BITS'(req_address)}
                                       : {rd_lvl, rd_pos};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_addr] <= req_word;
      end
      rdata_ff <= mem_ram[mem_addr];
   end

   // word capture
   always_ff @(posedge clock) begin
      if (cmd.ld_en) begin
         w_ff[cmd.ld_idx] <= rdata_ff;
      end
   end

   // shared multiplier operands
   assign diff_lo = mwo_pkg::DIFF_W'(w_ff[1]) - mwo_pkg::DIFF_W'(w_ff[0]);
   assign diff_hi = mwo_pkg::DIFF_W'(w_ff[3]) - mwo_pkg::DIFF_W'(w_ff[2]);

   always_comb begin
      case (cmd.mul_sel)
         mwo_pkg::MUL_LO: begin
            mul_x = mwo_pkg::MOP_W'(diff_lo);
            mul_y = signed'(mwo_pkg::MOP_W'(frac));
         end
         mwo_pkg::MUL_HI: begin
            mul_x = mwo_pkg::MOP_W'(diff_hi);
            mul_y = signed'(mwo_pkg::MOP_W'(frac));
         end
         mwo_pkg::MUL_DL: begin
            mul_x = signed'(mwo_pkg::MOP_W'(d_ff[mwo_pkg::DL_W-1:0]));
            mul_y = signed'(mwo_pkg::MOP_W'(mix_ff));
         end
         mwo_pkg::MUL_DH: begin
            mul_x = mwo_pkg::MOP_W'(signed'(d_ff[mwo_pkg::D_W-1:mwo_pkg::DL_W]));
            mul_y = signed'(mwo_pkg::MOP_W'(mix_ff));
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign prod_in = mul_x * mul_y;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // one level: a * 2^F + (b - a) * f, base word picked by which level is done
   assign o_sum = mwo_pkg::O_W'(signed'({(cmd.o1_en ? w_ff[0] : w_ff[2]),
                                         mwo_pkg::FRAC_BITS'(0)}))
                + mwo_pkg::O_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (cmd.o1_en) begin
         o1_ff <= o_sum;
      end
      if (cmd.o2_en) begin
         o2_ff <= o_sum;
      end
   end

   // crossfade: o1 * 2^16 + (o2 - o1) * m, the product split in two slices
   always_ff @(posedge clock) begin
      if (cmd.d_en) begin
         d_ff   <= mwo_pkg::D_W'(o2_ff) - mwo_pkg::D_W'(o1_ff);
         acc_ff <= mwo_pkg::ACC_W'(signed'({o1_ff, mwo_pkg::MIX_BITS'(0)}));
      end else if (cmd.acc_add_lo) begin
         acc_ff <= acc_ff + mwo_pkg::ACC_W'(prod_ff);
      end else if (cmd.acc_add_hi) begin
         acc_ff <= acc_ff + mwo_pkg::ACC_W'(signed'({prod_ff, mwo_pkg::DL_W'(0)}));
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_en) begin
         rsp_sample_ff <= acc_ff[mwo_pkg::OUT_LSB +: mwo_pkg::SAMPLE_BITS];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

endmodule

@@ src/mipmapped_wavetable_oscillator_top.sv @@
// Mipmapped wavetable oscillator: a table write is accepted back to back while idle.
// A tick reads four words through the single table port, then runs interpolation and
// crossfade through one shared multiplier: rsp_valid rises once the result is loaded into the
// output register; the next item waits until the tick is done (longer if rsp_ready is low).
// Synchronous reset clears phase, config registers and control; table contents stay
// undefined until written, with no clearing pass.
module mipmapped_wavetable_oscillator_top #(
   parameter int LEVELS = 11
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_operation,
   input  logic [mwo_pkg::SHIFT_BITS-1:0]         req_shift,
   input  logic [mwo_pkg::LEVEL_BITS-1:0]         req_level,
   input  logic [mwo_pkg::ADDR_FIELD_BITS-1:0]    req_address,
   input  logic signed [mwo_pkg::SAMPLE_BITS-1:0] req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [mwo_pkg::SAMPLE_BITS-1:0] rsp_sample,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mwo_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mwo_pkg::STEP_BITS-1:0]          csr_data
);

   mwo_pkg::ctl_cmd_type   cmd;
   mwo_pkg::dp_status_type status;

   // config port always takes a word
   assign csr_ready = 1'b1;

   mwo_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   mwo_datapath #(
      .LEVELS (LEVELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_shift   (req_shift),
      .req_level   (req_level),
      .req_address (req_address),
      .req_word    (req_word),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_sample  (rsp_sample),
      .status      (status)
   );

   // a table write never produces a result word
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_operation == mwo_pkg::OP_WRITE)) |=> !$rose(rsp_valid))
      else $error("result word appeared after a table write");

   // a tick holds off the input side while it is in flight
   a_tick_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_operation == mwo_pkg::OP_TICK)) |=> !req_ready)
      else $error("input accepted while a tick is in flight");

   // the multiplier only runs on a tick in flight
   a_mul_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_en |-> (!req_ready && !cmd.word_write))
      else $error("multiplier active while idle");

endmodule

@@ tb/mipmapped_wavetable_oscillator_top_tb.sv @@
// self-checking testbench for the mipmapped wavetable oscillator top level
module mipmapped_wavetable_oscillator_top_tb;

   localparam int LEVELS        = 11;
   localparam int WAVE_LEN      = mwo_pkg::WAVE_LEN;
   localparam int LIMIT         = 1500000;
   localparam int SETTLE_CYCLES = 20;
   localparam int LONG_HOLD     = 400;
   localparam int PHASE_ITEMS   = 260;

   // ticks only read inside a window of written words that wraps past the table end
   localparam int WIN_BASE = WAVE_LEN - 8;
   localparam int WIN_LEN  = 32;

   localparam int STEP_W  = mwo_pkg::STEP_BITS;
   localparam int FRAC_W  = mwo_pkg::FRAC_BITS;
   localparam int SAMP_W  = mwo_pkg::SAMPLE_BITS;
   localparam int MIX_W   = mwo_pkg::MIX_BITS;
   localparam int LEVEL_W = mwo_pkg::LEVEL_BITS;
   localparam int SHIFT_W = mwo_pkg::SHIFT_BITS;
   localparam int ADDR_W  = mwo_pkg::ADDR_FIELD_BITS;
   localparam int IDX_W   = mwo_pkg::CSR_INDEX_BITS;

   localparam logic [STEP_W-1:0] NYQUIST_STEP = STEP_W'((WAVE_LEN / 2) * (1 << FRAC_W));
   localparam logic [STEP_W-1:0] STEP_ALL_ONES = {STEP_W{1'b1}};
   localparam logic [IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic signed [SAMP_W-1:0] WORD_MAX = 16'sh7FFF;
   localparam logic signed [SAMP_W-1:0] WORD_MIN = 16'sh8000;
   localparam logic [MIX_W-1:0] MIX_MAX = 16'hFFFF;
   localparam logic [MIX_W-1:0] MIX_HALF = 16'h8000;

   // tracks table, phase and registers, and queues the samples each tick must give
   class sample_scoreboard;
      logic signed [SAMP_W-1:0] wave_mem [LEVELS][WAVE_LEN];
      logic [STEP_W-1:0]        phase_acc;
      logic [STEP_W-1:0]        step_reg;
      logic [LEVEL_W-1:0]       octave_reg;
      logic [MIX_W-1:0]         mix_reg;
      logic signed [SAMP_W-1:0] pending_samples [$];
      int                       errors;

      function new();
         phase_acc  = '0;
         step_reg   = '0;
         octave_reg = '0;
         mix_reg    = '0;
         errors     = 0;
      endfunction

      task report(string what, logic signed [SAMP_W-1:0] got,
                  logic signed [SAMP_W-1:0] want);
         $display("mismatch: %s, got %0d expected %0d", what, got, want);
         errors++;
      endtask

      function void write_reg(logic [IDX_W-1:0] index, logic [STEP_W-1:0] data);
         case (index)
            mwo_pkg::CSR_PHASE_STEP:
               step_reg = (data > NYQUIST_STEP) ? NYQUIST_STEP : data;
            mwo_pkg::CSR_OCTAVE_INDEX: octave_reg = data[LEVEL_W-1:0];
            mwo_pkg::CSR_OCTAVE_MIX:   mix_reg    = data[MIX_W-1:0];
            default: ;
         endcase
      endfunction

      // one level, two neighbor words weighted by the phase fraction
      function longint level_interp(int lvl, int pos, longint frac);
         int     nxt;
         longint a;
         longint b;
         nxt = (pos + 1) % WAVE_LEN;
         a   = wave_mem[lvl][pos];
         b   = wave_mem[lvl][nxt];
         return a * ((64'sd1 << FRAC_W) - frac) + b * frac;
      endfunction

      function void note_item(logic op, logic [SHIFT_W-1:0] shift,
                              logic [LEVEL_W-1:0] level, logic [ADDR_W-1:0] addr,
                              logic signed [SAMP_W-1:0] word);
         int                       lo;
         int                       hi;
         int                       pos;
         longint                   frac;
         longint                   mix;
         longint                   o1;
         longint                   o2;
         longint                   acc;
         logic signed [SAMP_W-1:0] sample;
         if (op == mwo_pkg::OP_WRITE) begin
            // writes past the last level are dropped
            if (level < LEVELS) wave_mem[level][addr] = word;
            return;
         end
         lo   = (octave_reg > LEVELS - 1) ? LEVELS - 1 : int'(octave_reg);
         hi   = (lo + 1 > LEVELS - 1) ? LEVELS - 1 : lo + 1;
         pos  = (int'(phase_acc >> FRAC_W) + int'(shift)) % WAVE_LEN;
         frac = phase_acc[FRAC_W-1:0];
         mix  = mix_reg;
         o1   = level_interp(lo, pos, frac);
         o2   = level_interp(hi, pos, frac);
         // crossfade, then floor by taking the bits above the fraction
         acc    = o1 * ((64'sd1 << MIX_W) - mix) + o2 * mix;
         sample = acc[mwo_pkg::OUT_LSB +: SAMP_W];
         pending_samples.push_back(sample);
         // phase wraps at the table size, which is the full register width
         phase_acc = phase_acc + step_reg;
      endfunction

      task check_sample(logic signed [SAMP_W-1:0] got);
         logic signed [SAMP_W-1:0] want;
         if (pending_samples.size() == 0) begin
            report("sample with no tick pending", got, '0);
            return;
         end
         want = pending_samples.pop_front();
         if (got !== want) report("sample", got, want);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid     = 1'b0;
   logic                     req_ready;
   logic                     req_operation = 1'b0;
   logic [SHIFT_W-1:0]       req_shift     = '0;
   logic [LEVEL_W-1:0]       req_level     = '0;
   logic [ADDR_W-1:0]        req_address   = '0;
   logic signed [SAMP_W-1:0] req_word      = '0;
   logic                     rsp_valid;
   logic                     rsp_ready     = 1'b0;
   logic signed [SAMP_W-1:0] rsp_sample;
   logic                     csr_valid     = 1'b0;
   logic                     csr_ready;
   logic [IDX_W-1:0]         csr_index     = '0;
   logic [STEP_W-1:0]        csr_data      = '0;

   // driver-side copy of phase and step, used to aim each tick into the window
   logic [STEP_W-1:0] drv_phase = '0;
   logic [STEP_W-1:0] drv_step  = '0;

   bit req_gaps_on   = 1'b0;
   bit rsp_gaps_on   = 1'b0;
   bit long_hold_req = 1'b0;
   int cycle_count   = 0;

   sample_scoreboard sb;

   mipmapped_wavetable_oscillator_top #(
      .LEVELS (LEVELS)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_shift     (req_shift),
      .req_level     (req_level),
      .req_address   (req_address),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sample    (rsp_sample),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #1 clock = ~clock;

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // monitor every accepted word on all three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_item(req_operation, req_shift, req_level, req_address, req_word);
         if (rsp_valid && rsp_ready) sb.check_sample(rsp_sample);
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
      end
   end

   // result side back-pressure, random stalls plus one long hold on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left == 0 && long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
         end else if (stall_left == 0 && rsp_gaps_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // offer one input word and hold it until accepted
   task automatic send_item(logic op, logic [SHIFT_W-1:0] shift,
                            logic [LEVEL_W-1:0] level, logic [ADDR_W-1:0] addr,
                            logic signed [SAMP_W-1:0] word);
      int gap;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_shift     <= shift;
      req_level     <= level;
      req_address   <= addr;
      req_word      <= word;
      do @(posedge clock); while (!req_ready);
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // tick whose read pair lands on window entries k and k + 1
   task automatic send_tick(int k);
      int pos;
      int shift_val;
      pos       = (WIN_BASE + k) % WAVE_LEN;
      shift_val = (pos - int'(drv_phase >> FRAC_W)) & (WAVE_LEN - 1);
      send_item(mwo_pkg::OP_TICK, SHIFT_W'(shift_val), LEVEL_W'($urandom),
                ADDR_W'($urandom), SAMP_W'($urandom));
      drv_phase = drv_phase + drv_step;
   endtask

   // table write to window entry k of one level
   task automatic send_win_write(int level, int k, logic signed [SAMP_W-1:0] word);
      send_item(mwo_pkg::OP_WRITE, SHIFT_W'($urandom), LEVEL_W'(level),
                ADDR_W'((WIN_BASE + k) % WAVE_LEN), word);
   endtask

   // register writes back to back, upper data bits random to check masking
   task automatic load_regs(logic [STEP_W-1:0] step, logic [LEVEL_W-1:0] octave,
                            logic [MIX_W-1:0] mix, bit with_unused);
      logic [IDX_W-1:0]  idx_list [4];
      logic [STEP_W-1:0] data_list [4];
      int                n;
      drv_step  = (step > NYQUIST_STEP) ? NYQUIST_STEP : step;
      idx_list  = '{mwo_pkg::CSR_PHASE_STEP, mwo_pkg::CSR_OCTAVE_INDEX,
                    mwo_pkg::CSR_OCTAVE_MIX, CSR_UNUSED_INDEX};
      data_list = '{step,
                    {23'($urandom), octave},
                    {11'($urandom), mix},
                    STEP_W'($urandom)};
      n = with_unused ? 4 : 3;
      for (int i = 0; i < n; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx_list[i];
         csr_data  <= data_list[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // wait until every queued sample has come back and the block has settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly ticks and window writes, some stray writes and writes to missing levels
   task automatic send_random_items(int count);
      int done_n;
      int r;
      done_n = 0;
      while (done_n < count) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            send_tick($urandom_range(0, WIN_LEN - 2));
         end else if (r < 88) begin
            send_win_write($urandom_range(0, LEVELS - 1), $urandom_range(0, WIN_LEN - 1),
                           SAMP_W'($urandom));
         end else if (r < 94) begin
            send_item(mwo_pkg::OP_WRITE, SHIFT_W'($urandom),
                      LEVEL_W'($urandom_range(0, LEVELS - 1)),
                      ADDR_W'($urandom), SAMP_W'($urandom));
         end else begin
            send_item(mwo_pkg::OP_WRITE, SHIFT_W'($urandom),
                      LEVEL_W'($urandom_range(LEVELS, 15)),
                      ADDR_W'($urandom), SAMP_W'($urandom));
         end
         done_n++;
      end
   endtask

   task automatic random_phase(logic [STEP_W-1:0] step, logic [LEVEL_W-1:0] octave,
                               logic [MIX_W-1:0] mix, bit gaps, bit hold, int count);
      load_regs(step, octave, mix, 1'($urandom_range(0, 1)));
      req_gaps_on = gaps;
      rsp_gaps_on = gaps;
      if (hold) long_hold_req = 1'b1;
      send_random_items(count);
      wait_idle();
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the window in every level so no tick can land on an unwritten word
      for (int l = 0; l < LEVELS; l++)
         for (int k = 0; k < WIN_LEN; k++)
            send_win_write(l, k, SAMP_W'($urandom));
      wait_idle();

      // directed: extreme words, wrap of the next address, dropped write
      load_regs('0, '0, '0, 1'b0);
      send_item(mwo_pkg::OP_WRITE, '0, 4'd0, 11'd0, WORD_MAX);
      send_item(mwo_pkg::OP_WRITE, '0, 4'd0, 11'd1, WORD_MIN);
      send_item(mwo_pkg::OP_WRITE, '0, 4'd1, 11'd0, WORD_MIN);
      send_item(mwo_pkg::OP_WRITE, '0, 4'd1, 11'd1, WORD_MAX);
      send_item(mwo_pkg::OP_WRITE, '0, 4'd0, 11'd2047, WORD_MIN);
      send_tick(8);
      send_tick(7);
      send_item(mwo_pkg::OP_WRITE, '0, 4'd15, 11'd0, WORD_MAX);
      send_item(mwo_pkg::OP_WRITE, '0, 4'd10, 11'd2047, WORD_MIN);
      send_item(mwo_pkg::OP_WRITE, '0, 4'd10, 11'd0, WORD_MAX);
      send_tick(9);
      wait_idle();

      // directed: step above nyquist, level index past the top, full mix
      load_regs(STEP_ALL_ONES, 4'd15, MIX_MAX, 1'b1);
      send_tick(7);
      send_tick(8);
      send_tick(20);
      send_tick(7);
      wait_idle();

      // directed: fractional step at the top level, half mix
      load_regs(27'h18000, 4'd10, MIX_HALF, 1'b0);
      send_item(mwo_pkg::OP_WRITE, '0, 4'd10, 11'd1, WORD_MAX);
      send_tick(8);
      send_tick(8);
      send_tick(7);
      send_tick(13);
      send_tick(6);
      wait_idle();

      // random phases across register settings
      random_phase(STEP_W'($urandom_range(1, 1 << 18)), 4'd0, MIX_W'($urandom),
                   1'b1, 1'b0, PHASE_ITEMS);
      random_phase(NYQUIST_STEP, 4'd10, MIX_MAX, 1'b1, 1'b1, PHASE_ITEMS);
      random_phase(STEP_W'($urandom), LEVEL_W'($urandom), MIX_W'($urandom),
                   1'b0, 1'b0, PHASE_ITEMS);
      random_phase('0, 4'd9, '0, 1'b1, 1'b0, PHASE_ITEMS);
      random_phase(STEP_W'($urandom_range(1, 1 << 24)), 4'd15, 16'd1, 1'b1, 1'b0,
                   PHASE_ITEMS);
      random_phase(STEP_W'($urandom), LEVEL_W'($urandom_range(0, 10)),
                   MIX_W'($urandom), 1'b1, 1'b0, PHASE_ITEMS);

      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
